### rtl/core/gbes_pkg.sv
package gbes_pkg;

   // Fixed widths of the transaction fields.
   localparam int NODE_FIELD_W = 6;
   localparam int DRAW_W       = 16;
   localparam int THRESH_W     = 17;
   localparam int CSR_INDEX_W  = 2;

   // Node indices that the node field can address at all.
   localparam int NODE_LIMIT = 2 ** NODE_FIELD_W;

   // Default node count of the store.
   localparam int NODES_DEFAULT = 64;

   // Operation codes carried in the request tuser.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_ROUND  = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   // Stored decision of one node pair.
   typedef enum logic [1:0] {
      PAIR_UNDECIDED = 2'd0,
      PAIR_NO_EDGE   = 2'd1,
      PAIR_EDGE      = 2'd2
   } pair_dec_type;

   // Configuration register indices.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NODE_THRESHOLD = 2'd0,
      CSR_EDGE_THRESHOLD = 2'd1
   } csr_index_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_SWEEP = 2'd0,
      ST_IDLE  = 2'd1,
      ST_ROUND = 2'd2,
      ST_QUERY = 2'd3
   } state_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      op_type                  op;
      logic                    sample_hit;
      logic                    edge_hit;
      logic                    pair_ok;
      logic [NODE_FIELD_W-1:0] node;
      logic [NODE_FIELD_W-1:0] other;
   } cmd_type;

endpackage

### rtl/core/gbes_ram.sv
module gbes_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/gbes_front.sv
module gbes_front #(
   parameter int NODES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gbes_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gbes_pkg::THRESH_W-1:0]       csr_wdata,
   input  logic                                store_ready,
   output logic                                push_valid,
   input  logic                                push_ready,
   output gbes_pkg::cmd_type                   push_data
);

   import gbes_pkg::*;

   localparam int EFF_NODES = (NODES < NODE_LIMIT) ? NODES : NODE_LIMIT;
   localparam logic [NODE_FIELD_W:0] EFF_NODES_V = (NODE_FIELD_W + 1)'(EFF_NODES);

   logic [THRESH_W-1:0]     node_thr_ff, node_thr_in;
   logic [THRESH_W-1:0]     edge_thr_ff, edge_thr_in;
   logic [NODE_FIELD_W-1:0] node;
   logic [NODE_FIELD_W-1:0] other;
   logic [DRAW_W-1:0]       draw;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      node_thr_in = node_thr_ff;
      edge_thr_in = edge_thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NODE_THRESHOLD: node_thr_in = csr_wdata;
            CSR_EDGE_THRESHOLD: edge_thr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_thr_ff <= '0;
         edge_thr_ff <= '0;
      end else begin
         node_thr_ff <= node_thr_in;
         edge_thr_ff <= edge_thr_in;
      end
   end

   // Unpack the request payload.
   assign node  = req_tdata[NODE_FIELD_W-1:0];
   assign other = req_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W];
   assign draw  = req_tdata[2*NODE_FIELD_W+DRAW_W-1:2*NODE_FIELD_W];

   // Classify the transaction and precompute both threshold compares.
   always_comb begin
      push_data.op         = op_type'(req_tuser);
      push_data.sample_hit = ({1'b0, node} < EFF_NODES_V) && ({1'b0, draw} < node_thr_ff);
      push_data.edge_hit   = {1'b0, draw} < edge_thr_ff;
      push_data.pair_ok    = (node < other) && ({1'b0, other} < EFF_NODES_V);
      push_data.node       = node;
      push_data.other      = other;
   end

   // Hold requests off while the store is being swept.
   assign push_valid = req_tvalid && store_ready;
   assign req_tready = push_ready && store_ready;

endmodule

### rtl/core/gbes_queue.sv
module gbes_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gbes_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gbes_pkg::cmd_type pop_data
);

   import gbes_pkg::*;

   localparam int DEPTH   = 2;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != COUNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_W'(do_push) - COUNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command slots hold payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/gbes_back.sv
module gbes_back #(
   parameter int NODES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  gbes_pkg::cmd_type pop_data,
   output logic              store_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser
);

   import gbes_pkg::*;

   localparam int EFF_NODES = (NODES < NODE_LIMIT) ? NODES : NODE_LIMIT;
   localparam int ROW_W     = $clog2(EFF_NODES);
   localparam int CNT_W     = $clog2(EFF_NODES + 1);
   localparam int ROW_BITS  = 2 * EFF_NODES;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [ROW_W-1:0]      pend_row_ff, pend_row_in;
   pair_dec_type          outcome_ff, outcome_in;
   logic [ROW_W-1:0]      q_other_ff, q_other_in;
   logic                  q_edge_ff, q_edge_in;
   logic [EFF_NODES-1:0]  chosen_ff, chosen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_edge_ff, rsp_edge_in;
   logic                  rsp_decided_ff, rsp_decided_in;
   logic                  rsp_invalid_ff, rsp_invalid_in;

   logic                  rd_en;
   logic [ROW_W-1:0]      rd_addr;
   logic [ROW_BITS-1:0]   rd_data;
   logic                  wr_en;
   logic [ROW_W-1:0]      wr_addr;
   logic [ROW_BITS-1:0]   wr_data;
   logic [ROW_BITS-1:0]   merged;
   logic [1:0]            q_entry;
   logic                  out_free;
   logic                  out_load;
   logic                  out_edge;
   logic                  out_decided;
   logic                  out_invalid;

   // One row per lower node, two bits per higher node.
   gbes_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (EFF_NODES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Binding round: undecided pairs among chosen nodes take the round outcome.
   always_comb begin
      merged = rd_data;
      for (int b = 0; b < EFF_NODES; b++) begin
         if (chosen_ff[b] && chosen_ff[pend_row_ff] && (b > int'(pend_row_ff))
             && (rd_data[2*b +: 2] == PAIR_UNDECIDED)) begin
            merged[2*b +: 2] = outcome_ff;
         end
      end
   end

   assign q_entry  = rd_data[{q_other_ff, 1'b0} +: 2];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: next state, store access and result load.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pend_row_in = cnt_ff[ROW_W-1:0];
      outcome_in  = outcome_ff;
      q_other_in  = q_other_ff;
      q_edge_in   = q_edge_ff;
      chosen_in   = chosen_ff;
      pop_ready   = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[ROW_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[ROW_W-1:0];
      wr_data     = '0;
      out_load    = 1'b0;
      out_edge    = 1'b0;
      out_decided = 1'b0;
      out_invalid = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            // Write every row back to undecided.
            wr_en = 1'b1;
            if (cnt_ff == CNT_W'(EFF_NODES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_data.op)
                  OP_CLEAR: begin
                     pop_ready = 1'b1;
                     cnt_in    = '0;
                     state_in  = ST_SWEEP;
                  end
                  OP_SAMPLE: begin
                     pop_ready = 1'b1;
                     if (pop_data.sample_hit) begin
                        chosen_in[pop_data.node[ROW_W-1:0]] = 1'b1;
                     end
                  end
                  OP_ROUND: begin
                     pop_ready  = 1'b1;
                     outcome_in = pop_data.edge_hit ? PAIR_EDGE : PAIR_NO_EDGE;
                     cnt_in     = '0;
                     state_in   = ST_ROUND;
                  end
                  OP_QUERY: begin
                     if (out_free) begin
                        pop_ready = 1'b1;
                        if (!pop_data.pair_ok) begin
                           out_load    = 1'b1;
                           out_invalid = 1'b1;
                        end else begin
                           rd_en      = 1'b1;
                           rd_addr    = pop_data.node[ROW_W-1:0];
                           q_other_in = pop_data.other[ROW_W-1:0];
                           q_edge_in  = pop_data.edge_hit;
                           state_in   = ST_QUERY;
                        end
                     end
                  end
               endcase
            end
         end

         ST_ROUND: begin
            // Read row k while the merged row k-1 is written back.
            if (cnt_ff < CNT_W'(EFF_NODES)) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_row_ff;
               wr_data = merged;
            end
            if (cnt_ff == CNT_W'(EFF_NODES)) begin
               chosen_in = '0;
               cnt_in    = '0;
               state_in  = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         ST_QUERY: begin
            // The row is back: pick the pair and load the result.
            out_load = 1'b1;
            unique case (q_entry)
               PAIR_EDGE: begin
                  out_edge    = 1'b1;
                  out_decided = 1'b1;
               end
               PAIR_NO_EDGE: begin
                  out_decided = 1'b1;
               end
               default: begin
                  out_edge = q_edge_ff;
               end
            endcase
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register, loaded only when empty or being drained.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_edge_in    = rsp_edge_ff;
      rsp_decided_in = rsp_decided_ff;
      rsp_invalid_in = rsp_invalid_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_edge_in    = out_edge;
         rsp_decided_in = out_decided;
         rsp_invalid_in = out_invalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         chosen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         chosen_ff    <= chosen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff    <= pend_row_in;
      outcome_ff     <= outcome_in;
      q_other_ff     <= q_other_in;
      q_edge_ff      <= q_edge_in;
      rsp_edge_ff    <= rsp_edge_in;
      rsp_decided_ff <= rsp_decided_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign store_ready = state_ff != ST_SWEEP;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {6'b0, rsp_decided_ff, rsp_edge_ff};
   assign rsp_tuser   = rsp_invalid_ff;

endmodule

### rtl/core/group_bound_edge_sampler.sv
// A pair query result is loaded into the output register once its store row read
// is back; an invalid pair loads the output register with no row read.
// The back end takes a node sample straight away but holds a pair query until
// its row is back; end round and clear store walk the store one row a cycle.
// Reset clears thresholds and the chosen set and starts a sweep of the pair
// store, during which req_tready stays low.
module group_bound_edge_sampler #(
   parameter int NODES = gbes_pkg::NODES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // node [5:0], other_node [11:6], draw [27:12], zero [31:28]
   input  logic [31:0]                      req_tdata,
   // operation [1:0]
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // edge_present [0], was_decided [1], zero [7:2]
   output logic [7:0]                       rsp_tdata,
   // pair_invalid [0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gbes_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbes_pkg::THRESH_W-1:0]    csr_wdata
);

   import gbes_pkg::*;

   logic    store_ready;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   // Front end: configuration and request classification.
   gbes_front #(
      .NODES (NODES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .store_ready (store_ready),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // Command queue between front and back.
   gbes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: pair store, chosen set and result register.
   gbes_back #(
      .NODES (NODES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .store_ready (store_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

### sim/testbench.sv
module testbench;
   import gbes_pkg::*;

   localparam int NODE_COUNT     = NODES_DEFAULT;
   // Rounds and clears walk one store row a cycle, and one may be running with
   // two more queued behind it, so let them all finish before the thresholds
   // change.
   localparam int SETTLE_CYCLES  = 4 * (NODE_COUNT + 2) + 16;
   localparam int DRAIN_LIMIT    = 200000;
   localparam int RUN_LIMIT      = 6000000;
   localparam int CHUNKS_PER_RUN = 4;
   localparam int CHUNK_ITEMS    = 115;

   // One query answer as it leaves the block.
   typedef struct packed {
      logic edge_present;
      logic was_decided;
      logic pair_invalid;
   } answer_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [THRESH_W-1:0]    csr_wdata  = '0;

   // Mirror of the block's state and settings.
   pair_dec_type           pair_store [NODE_COUNT][NODE_COUNT];
   logic [NODE_COUNT-1:0]  chosen_set;
   logic [THRESH_W-1:0]    node_thr;
   logic [THRESH_W-1:0]    edge_thr;
   answer_type             pending_answers [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int items_sent     = 0;
   int sample_count   = 0;
   int round_count    = 0;
   int clear_count    = 0;
   int query_count    = 0;
   int decided_count  = 0;
   int invalid_count  = 0;
   int setting_count  = 0;

   group_bound_edge_sampler #(
      .NODES(NODE_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT);
      $display("FAIL");
      $finish;
   end

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("Mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void clear_pair_store();
      for (int a = 0; a < NODE_COUNT; a++) begin
         for (int b = 0; b < NODE_COUNT; b++) begin
            pair_store[a][b] = PAIR_UNDECIDED;
         end
      end
   endfunction

   // Apply one accepted transaction to the mirrored store and queue the answer
   // that a pair query should produce.
   task update_pair_model(input op_type op, input logic [5:0] node, input logic [5:0] other,
                          input logic [15:0] draw);
      pair_dec_type outcome;
      answer_type   answer;
      case (op)
         OP_CLEAR: begin
            clear_pair_store();
            clear_count++;
         end
         OP_SAMPLE: begin
            if ({1'b0, draw} < node_thr) begin
               chosen_set[node] = 1'b1;
            end
            sample_count++;
         end
         OP_ROUND: begin
            outcome = ({1'b0, draw} < edge_thr) ? PAIR_EDGE : PAIR_NO_EDGE;
            for (int a = 0; a < NODE_COUNT; a++) begin
               for (int b = a + 1; b < NODE_COUNT; b++) begin
                  if (chosen_set[a] && chosen_set[b] && pair_store[a][b] == PAIR_UNDECIDED) begin
                     pair_store[a][b] = outcome;
                  end
               end
            end
            chosen_set = '0;
            round_count++;
         end
         default: begin
            answer = '0;
            if (node >= other) begin
               answer.pair_invalid = 1'b1;
               invalid_count++;
            end else if (pair_store[node][other] == PAIR_UNDECIDED) begin
               answer.edge_present = ({1'b0, draw} < edge_thr);
            end else begin
               answer.edge_present = (pair_store[node][other] == PAIR_EDGE);
               answer.was_decided  = 1'b1;
               decided_count++;
            end
            pending_answers = {pending_answers, answer};
            query_count++;
         end
      endcase
   endtask

   // Offer one transaction, idling first at the current rate, and record it
   // in the model once it is taken.
   task send_item(input op_type op, input logic [5:0] node, input logic [5:0] other,
                  input logic [15:0] draw);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, draw, other, node};
      do @(posedge clock); while (!req_tready);
      update_pair_model(op, node, other, draw);
      items_sent++;
   endtask

   // Hold the sender until every query has been answered.
   task drain_answers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task wait_idle();
      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes; the caller lowers csr_valid after the last one.
   task write_register(input csr_index_type index, input logic [THRESH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_NODE_THRESHOLD) begin
         node_thr = value;
      end else begin
         edge_thr = value;
      end
   endtask

   task set_thresholds(input logic [THRESH_W-1:0] node_value,
                       input logic [THRESH_W-1:0] edge_value);
      wait_idle();
      write_register(CSR_NODE_THRESHOLD, node_value);
      write_register(CSR_EDGE_THRESHOLD, edge_value);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // Edge cases of the sampling and round logic, at full rate on both sides.
   task test_special_cases();
      set_thresholds(17'h08000, 17'h08000);
      // Undecided and invalid pairs.
      send_item(OP_QUERY, 6'd0, 6'd63, 16'h0000);
      send_item(OP_QUERY, 6'd0, 6'd63, 16'hFFFF);
      send_item(OP_QUERY, 6'd63, 6'd0, 16'h0000);
      send_item(OP_QUERY, 6'd17, 6'd17, 16'h0000);
      // A chosen node stays chosen after a miss; draws either side of the threshold.
      send_item(OP_SAMPLE, 6'd5, 6'd0, 16'h0000);
      send_item(OP_SAMPLE, 6'd5, 6'd63, 16'hFFFF);
      send_item(OP_SAMPLE, 6'd63, 6'd0, 16'h7FFF);
      send_item(OP_SAMPLE, 6'd0, 6'd0, 16'h8000);
      // Clearing the store keeps the chosen set.
      send_item(OP_CLEAR, 6'd63, 6'd63, 16'hFFFF);
      send_item(OP_ROUND, 6'd0, 6'd0, 16'h7FFF);
      send_item(OP_QUERY, 6'd5, 6'd63, 16'hFFFF);
      send_item(OP_QUERY, 6'd0, 6'd5, 16'hFFFF);
      // A decided pair keeps its first outcome in a later round.
      send_item(OP_SAMPLE, 6'd5, 6'd0, 16'h0000);
      send_item(OP_SAMPLE, 6'd63, 6'd0, 16'h0000);
      send_item(OP_SAMPLE, 6'd0, 6'd0, 16'h0000);
      send_item(OP_ROUND, 6'd0, 6'd0, 16'hFFFF);
      send_item(OP_QUERY, 6'd5, 6'd63, 16'hFFFF);
      send_item(OP_QUERY, 6'd0, 6'd63, 16'h0000);
      // A round with a single chosen node changes nothing but empties the set.
      send_item(OP_SAMPLE, 6'd42, 6'd0, 16'h0000);
      send_item(OP_ROUND, 6'd0, 6'd0, 16'h0000);
      send_item(OP_SAMPLE, 6'd43, 6'd0, 16'h0000);
      send_item(OP_ROUND, 6'd0, 6'd0, 16'h0000);
      send_item(OP_QUERY, 6'd42, 6'd43, 16'hFFFF);
      send_item(OP_CLEAR, 6'd0, 6'd0, 16'h0000);
      send_item(OP_QUERY, 6'd5, 6'd63, 16'hFFFF);
   endtask

   // Random traffic in chunks, each under a fresh pair of thresholds. Most of
   // it is sample-round-query sequences over a small node group so that
   // queries land on decided pairs.
   task run_random_chunks();
      logic [5:0]          group [8];
      logic [5:0]          a;
      logic [5:0]          b;
      logic [5:0]          swap;
      logic [THRESH_W-1:0] node_value;
      logic [THRESH_W-1:0] edge_value;
      int                  size;
      int                  kind;
      int                  target;
      for (int chunk = 0; chunk < CHUNKS_PER_RUN; chunk++) begin
         case (setting_count % 6)
            0: node_value = 17'h10000;
            1: node_value = 17'h1FFFF;
            2: node_value = 17'($urandom_range(0, 65535));
            3: node_value = 17'($urandom);
            4: node_value = 17'h00000;
            default: node_value = 17'h08000;
         endcase
         case (setting_count % 5)
            0: edge_value = 17'h00000;
            1: edge_value = 17'h10000;
            2: edge_value = 17'h1FFFF;
            3: edge_value = 17'($urandom);
            default: edge_value = 17'($urandom_range(1, 65535));
         endcase
         set_thresholds(node_value, edge_value);
         target = items_sent + CHUNK_ITEMS;
         while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
               // Well-formed round: sample a group, close it, query within it.
               size = $urandom_range(2, 8);
               for (int i = 0; i < size; i++) begin
                  group[i] = 6'($urandom_range(0, 63));
                  send_item(OP_SAMPLE, group[i], 6'($urandom), 16'($urandom));
                  if ($urandom_range(0, 3) == 0) begin
                     send_item(OP_SAMPLE, group[i], 6'($urandom), 16'($urandom));
                  end
               end
               send_item(OP_ROUND, 6'($urandom), 6'($urandom), 16'($urandom));
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 6) == 0) begin
                     a = 6'($urandom);
                     b = 6'($urandom);
                  end else begin
                     a = group[$urandom_range(0, size - 1)];
                     b = group[$urandom_range(0, size - 1)];
                     if ($urandom_range(0, 9) < 8 && a > b) begin
                        swap = a;
                        a    = b;
                        b    = swap;
                     end
                  end
                  send_item(OP_QUERY, a, b, 16'($urandom));
               end
            end else if (kind < 83) begin
               send_item(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
            end else if (kind < 93) begin
               // Noise: any operation with any fields.
               repeat ($urandom_range(1, 4)) begin
                  send_item(op_type'($urandom_range(0, 3)), 6'($urandom), 6'($urandom),
                            16'($urandom));
               end
            end else begin
               // Broken sequence: samples with no round, then queries.
               size = $urandom_range(1, 3);
               for (int i = 0; i < size; i++) begin
                  group[i] = 6'($urandom_range(0, 63));
                  send_item(OP_SAMPLE, group[i], 6'($urandom), 16'($urandom));
               end
               repeat ($urandom_range(1, 3)) begin
                  send_item(OP_QUERY, group[$urandom_range(0, size - 1)],
                            6'($urandom), 16'($urandom));
               end
            end
            // Always in chunk 0, else now and then, drain all answers first.
            if (chunk == 0 || $urandom_range(0, 29) == 0) begin
               drain_answers();
            end
         end
      end
   endtask

   task test_sender_gaps();
      send_idle_pct  = 30;
      recv_stall_pct = 62;
      run_random_chunks();
   endtask

   task test_receiver_stalls();
      send_idle_pct  = 62;
      recv_stall_pct = 30;
      run_random_chunks();
   endtask

   task test_full_rate();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_chunks();
   endtask

   // Answer checker and receiver back-pressure.
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("answer with no query outstanding",
                               32'({rsp_tdata, 7'b0, rsp_tuser}), '0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tdata[0] !== want.edge_present) begin
                  report_mismatch("edge_present", 32'(rsp_tdata[0]), 32'(want.edge_present));
               end
               if (rsp_tdata[1] !== want.was_decided) begin
                  report_mismatch("was_decided", 32'(rsp_tdata[1]), 32'(want.was_decided));
               end
               if (rsp_tuser !== want.pair_invalid) begin
                  report_mismatch("pair_invalid", 32'(rsp_tuser), 32'(want.pair_invalid));
               end
               if (rsp_tdata[7:2] !== 6'b0) begin
                  report_mismatch("tdata padding", 32'(rsp_tdata[7:2]), '0);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin
      int cycles;
      clear_pair_store();
      chosen_set = '0;
      node_thr   = '0;
      edge_thr   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_sender_gaps();
      test_receiver_stalls();
      test_full_rate();

      // Let the last answers come back, then allow for any round still running.
      req_tvalid <= 1'b0;
      cycles = 0;
      do begin
         @(posedge clock);
         cycles++;
      end while (pending_answers.size() != 0 && cycles < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_answers.size() != 0) begin
         void'(pending_answers.pop_front());
         report_mismatch("query answer never arrived", '0, '0);
      end

      $display("Run covered %0d transactions: %0d samples, %0d rounds, %0d clears, %0d queries.",
               items_sent, sample_count, round_count, clear_count, query_count);
      $display("Queries hit %0d decided and %0d invalid pairs over %0d threshold settings.",
               decided_count, invalid_count, setting_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### group_bound_edge_sampler.f
rtl/core/gbes_pkg.sv
rtl/core/gbes_ram.sv
rtl/core/gbes_front.sv
rtl/core/gbes_queue.sv
rtl/core/gbes_back.sv
rtl/core/group_bound_edge_sampler.sv
sim/testbench.sv
